### src/scu_pkg.sv
package scu_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 6;
  localparam int unsigned StatusW = 3;
  localparam int unsigned DepthW  = 7;

  typedef enum logic [OpW-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_ADD       = 3'd2,
    OP_SUB       = 3'd3,
    OP_MUL       = 3'd4,
    OP_DIV       = 3'd5,
    OP_PEEK_TOP  = 3'd6,
    OP_PEEK_BOT  = 3'd7
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_FULL  = 3'd2,
    ST_DIV0  = 3'd3,
    ST_INDEX = 3'd4
  } status_e;

  // Command broadcast to every stack cell in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_PUSH  = 3'd1,
    CELL_POP   = 3'd2,
    CELL_LOAD  = 3'd3,
    CELL_SHIFT = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [DataW-1:0] wdata;
  } cell_cmd_t;

endpackage

### src/scu_if.sv
interface scu_in_if import scu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OpW-1:0]      opcode;
  logic signed [DataW-1:0] operand;
  logic [PosW-1:0]     position;

  modport source (output valid, output opcode, output operand, output position, input ready);
  modport sink   (input valid, input opcode, input operand, input position, output ready);
endinterface

interface scu_out_if import scu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic [StatusW-1:0]      status;
  logic [DepthW-1:0]       depth_now;

  modport source (output valid, output value, output status, output depth_now, input ready);
  modport sink   (input valid, input value, input status, input depth_now, output ready);
endinterface

### src/scu_cell.sv
module scu_cell import scu_pkg::*; (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [DataW-1:0] prev_data_i,
  input  logic [DataW-1:0] next_data_i,
  input  logic [DataW-1:0] next_read_i,
  output logic [DataW-1:0] data_o,
  output logic [DataW-1:0] read_o
);

  logic [DataW-1:0] data_q, data_d;
  logic [DataW-1:0] read_q, read_d;

  always_comb begin
    data_d = data_q;
    read_d = read_q;
    unique case (cmd_i.op)
      CELL_HOLD:  ;
      CELL_PUSH:  data_d = prev_data_i;
      CELL_POP:   data_d = next_data_i;
      // snapshot the entry, then walk snapshots toward the top
      CELL_LOAD:  read_d = data_q;
      CELL_SHIFT: read_d = next_read_i;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    read_q <= read_d;
  end

  assign data_o = data_q;
  assign read_o = read_q;

endmodule

### src/scu_div.sv
module scu_div import scu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic             done_o,
  output logic [DataW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q, busy_d;
  logic             fin_q, fin_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] rm_q, rm_d;
  logic [DataW-1:0] res_q, res_d;

  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;
  logic [DataW-1:0] quo_up;

  assign shifted = {rem_q, quo_q[DataW-1]};
  assign diff    = shifted - {1'b0, rm_q};
  assign quo_up  = quo_q + DataW'(rem_q != '0);

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    rm_d   = rm_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = left_i[DataW-1] ^ right_i[DataW-1];
      rem_d  = '0;
      quo_d  = left_i[DataW-1] ? (DataW'(0) - left_i) : left_i;
      rm_d   = right_i[DataW-1] ? (DataW'(0) - right_i) : right_i;
    end else if (busy_q) begin
      // one restoring step per cycle
      if (!diff[DataW]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      // round toward minus infinity when signs differ
      res_d  = neg_q ? (DataW'(0) - quo_up) : quo_q;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    rm_q  <= rm_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

### src/stack_calculator_unit.sv
// Postfix calculator stack of 32-bit signed integers held in a row of shift cells, top
// entry in the first cell. One item is in flight at a time; a result sits in an output
// register while the next item is taken. Push, pop and the errors found at accept
// (too few operands, full stack, bad index) go straight to the done state; a zero divisor
// passes the second pop first; add, subtract and multiply pop twice and push the result;
// divide also runs a restoring divider that retires one quotient bit per cycle; a peek
// shifts its read snapshot one cell toward the top per cycle until the entry is on top.
// Results wait in the done state for a free output. No clearing is needed after reset.
module stack_calculator_unit import scu_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  scu_in_if.sink       in_i,
  scu_out_if.source    out_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam int unsigned WideW = (CntW > DepthW) ? CntW : DepthW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_POP2 = 6'b000010,
    S_DIV  = 6'b000100,
    S_PUSH = 6'b001000,
    S_PEEK = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  peek_cnt_q, peek_cnt_d;
  opcode_e          op_q, op_d;
  logic [DataW-1:0] left_q, left_d;
  logic [DataW-1:0] right_q, right_d;
  logic [DataW-1:0] res_value_q, res_value_d;
  status_e          res_status_q, res_status_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_value_q, out_value_d;
  status_e          out_status_q, out_status_d;
  logic [DepthW-1:0] out_depth_q, out_depth_d;

  cell_cmd_t        cmd;
  logic [DataW-1:0] cell_data [STACK_DEPTH];
  logic [DataW-1:0] cell_read [STACK_DEPTH];

  logic             div_start;
  logic             div_done;
  logic [DataW-1:0] div_quot;

  logic [WideW-1:0] count_w;
  logic [WideW-1:0] pos_w;
  logic [WideW-1:0] bot_idx;
  logic [DataW-1:0] prod;

  assign count_w = WideW'(count_q);
  assign pos_w   = WideW'(in_i.position);
  assign bot_idx = count_w - WideW'(1) - pos_w;
  assign prod    = left_q * right_q;

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic [DataW-1:0] prev_data;
    logic [DataW-1:0] next_data;
    logic [DataW-1:0] next_read;
    if (k == 0) begin : g_first
      assign prev_data = cmd.wdata;
    end else begin : g_mid
      assign prev_data = cell_data[k-1];
    end
    if (k == STACK_DEPTH - 1) begin : g_last
      assign next_data = '0;
      assign next_read = '0;
    end else begin : g_inner
      assign next_data = cell_data[k+1];
      assign next_read = cell_read[k+1];
    end
    scu_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .next_read_i (next_read),
      .data_o      (cell_data[k]),
      .read_o      (cell_read[k])
    );
  end

  scu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .left_i  (left_q),
    .right_i (right_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    peek_cnt_d   = peek_cnt_q;
    op_d         = op_q;
    left_d       = left_q;
    right_d      = right_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_depth_d  = out_depth_q;
    cmd.op       = CELL_HOLD;
    cmd.wdata    = in_i.operand;
    div_start    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          res_value_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_DONE;
          unique case (opcode_e'(in_i.opcode))
            OP_PUSH: begin
              if (count_q < CntW'(STACK_DEPTH)) begin
                cmd.op      = CELL_PUSH;
                count_d     = count_q + CntW'(1);
                res_value_d = in_i.operand;
              end else begin
                res_status_d = ST_FULL;
              end
            end
            OP_POP: begin
              if (count_q != '0) begin
                cmd.op      = CELL_POP;
                count_d     = count_q - CntW'(1);
                res_value_d = cell_data[0];
              end else begin
                res_status_d = ST_FEW;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (count_q >= CntW'(2)) begin
                cmd.op  = CELL_POP;
                count_d = count_q - CntW'(1);
                op_d    = opcode_e'(in_i.opcode);
                right_d = cell_data[0];
                left_d  = cell_data[1];
                state_d = S_POP2;
              end else begin
                res_status_d = ST_FEW;
              end
            end
            OP_PEEK_TOP, OP_PEEK_BOT: begin
              if (pos_w >= count_w) begin
                res_status_d = ST_INDEX;
              end else begin
                cmd.op     = CELL_LOAD;
                peek_cnt_d = (opcode_e'(in_i.opcode) == OP_PEEK_TOP) ?
                             pos_w[IdxW-1:0] : bot_idx[IdxW-1:0];
                state_d    = S_PEEK;
              end
            end
            default: ;
          endcase
        end
      end

      S_POP2: begin
        cmd.op  = CELL_POP;
        count_d = count_q - CntW'(1);
        unique case (op_q)
          OP_ADD: begin
            res_value_d = left_q + right_q;
            state_d     = S_PUSH;
          end
          OP_SUB: begin
            res_value_d = left_q - right_q;
            state_d     = S_PUSH;
          end
          OP_MUL: begin
            res_value_d = prod;
            state_d     = S_PUSH;
          end
          default: begin
            // divide: a zero divisor consumes both operands and pushes nothing
            if (right_q == '0) begin
              res_status_d = ST_DIV0;
              state_d      = S_DONE;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        endcase
      end

      S_DIV: begin
        if (div_done) begin
          res_value_d = div_quot;
          state_d     = S_PUSH;
        end
      end

      S_PUSH: begin
        cmd.op    = CELL_PUSH;
        cmd.wdata = res_value_q;
        count_d   = count_q + CntW'(1);
        state_d   = S_DONE;
      end

      S_PEEK: begin
        if (peek_cnt_q == '0) begin
          res_value_d = cell_read[0];
          state_d     = S_DONE;
        end else begin
          cmd.op     = CELL_SHIFT;
          peek_cnt_d = peek_cnt_q - IdxW'(1);
        end
      end

      S_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          out_depth_d  = count_w[DepthW-1:0];
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    peek_cnt_q   <= peek_cnt_d;
    op_q         <= op_d;
    left_q       <= left_d;
    right_q      <= right_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_depth_q  <= out_depth_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value     = out_value_q;
  assign out_o.status    = out_status_q;
  assign out_o.depth_now = out_depth_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("stack count exceeds capacity");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("result push did not grow the stack");

  a_peek_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PEEK) |-> (CntW'(peek_cnt_q) < count_q))
    else $error("peek walks past the live entries");
`endif

endmodule
